[sv/bfbp_pkg.sv]
// bfbp_pkg: sizes, payload types, cell control and candidate structs, fsm states
// for the best-fit bin packer; no dependencies

package bfbp_pkg;

    localparam int MAX_BINS  = 64;
    localparam int SIZE_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_BINS);
    localparam int CNT_W     = $clog2(MAX_BINS + 1);

    typedef logic [SIZE_BITS-1:0] t_size;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef struct packed {
        t_size item_size;
        logic  start_new_set;
    } t_in_item;

    typedef struct packed {
        t_idx  bin_index;
        logic  opened_new;
        t_cnt  bins_used;
        t_size room_after;
        logic  no_fit;
    } t_out_item;

    // best candidate handed from cell to cell
    typedef struct packed {
        logic  vld;
        logic  found;
        t_idx  idx;
        t_size room;
    } t_cand;

    // broadcast control to every cell
    typedef struct packed {
        logic  clr;
        logic  we;
        t_idx  widx;
        t_size wroom;
        logic  fit_ok;
        t_size size;
        t_size cap;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_state;

endpackage

[sv/bfbp_in_if.sv]
// bfbp_in_if: valid/ready request channel carrying one item to place
// depends on bfbp_pkg

interface bfbp_in_if;
    import bfbp_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/bfbp_out_if.sv]
// bfbp_out_if: valid/ready result channel carrying one placement result
// depends on bfbp_pkg

interface bfbp_out_if;
    import bfbp_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/bfbp_cell.sv]
// bfbp_cell: one bin of the chain, holds its room and in-use bit and
// refines the best-fit candidate passing through; depends on bfbp_pkg

module bfbp_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bfbp_pkg::t_idx       i_idx,
    input  bfbp_pkg::t_cell_ctrl i_ctrl,
    input  bfbp_pkg::t_cand      i_cand,
    output bfbp_pkg::t_cand      o_cand
);
    import bfbp_pkg::*;

    logic  r_in_use;
    t_size r_room;
    t_cand r_cand;
    t_size w_room;
    logic  w_take;

    assign w_room = r_in_use ? r_room : i_ctrl.cap;
    assign w_take = i_ctrl.fit_ok && (w_room >= i_ctrl.size)
                    && (!i_cand.found || (w_room < i_cand.room));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use   <= 1'b0;
            r_cand.vld <= 1'b0;
        end else begin
            r_cand.vld <= i_cand.vld;
            if (i_ctrl.clr) begin
                r_in_use <= 1'b0;
            end else if (i_ctrl.we && (i_ctrl.widx == i_idx)) begin
                r_in_use <= 1'b1;
            end
            if (i_cand.vld) begin
                if (w_take) begin
                    r_cand.found <= 1'b1;
                    r_cand.idx   <= i_idx;
                    r_cand.room  <= w_room;
                end else begin
                    r_cand.found <= i_cand.found;
                    r_cand.idx   <= i_cand.idx;
                    r_cand.room  <= i_cand.room;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we && (i_ctrl.widx == i_idx)) begin
            r_room <= i_ctrl.wroom;
        end
    end

    assign o_cand = r_cand;

endmodule

[sv/best_fit_bin_packing.sv]
// best_fit_bin_packing: online best-fit bin packer built as a chain of bin cells
// flow: accept registers the item, the candidate walks the chain of cells, then the chosen bin
// is written back and reported once the output is free; only then is the next item taken
// reset: synchronous active-low i_rst_n empties all bins, zeroes the count, capacity 65535
// depends on bfbp_pkg, bfbp_in_if, bfbp_out_if, bfbp_cell

module best_fit_bin_packing (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  bfbp_pkg::t_size        i_cfg_data,
    bfbp_in_if.sink                i_item,
    bfbp_out_if.source             o_res
);
    import bfbp_pkg::*;

    // control state
    t_state     r_state, n_state;
    logic       r_launch;
    t_cnt       r_count, n_count;
    t_size      r_cap;
    logic       r_out_vld, n_out_vld;

    // item payload held for the scan
    t_size      r_size;
    logic       r_fit_ok;
    t_out_item  r_out, n_out;

    // chain wiring
    t_cand      w_cand [MAX_BINS+1];
    t_cell_ctrl w_ctrl;
    t_cand      w_best;

    logic       w_accept;
    logic       w_out_free;
    logic       w_fresh;
    t_size      w_after;

    assign w_accept   = i_item.valid && i_item.ready;
    assign w_out_free = !r_out_vld || o_res.ready;
    assign w_best     = w_cand[MAX_BINS];

    // head of the chain: empty candidate, injected the cycle after accept
    assign w_cand[0].vld   = r_launch;
    assign w_cand[0].found = 1'b0;
    assign w_cand[0].idx   = '0;
    assign w_cand[0].room  = '0;

    assign w_fresh = (w_best.room == r_cap);
    assign w_after = w_best.room - r_size;

    // broadcast to cells: clear on a start request, write back the chosen bin
    always_comb begin
        w_ctrl.clr    = w_accept && i_item.payload.start_new_set;
        w_ctrl.we     = (r_state == ST_WRITE) && w_out_free && w_best.found;
        w_ctrl.widx   = w_best.idx;
        w_ctrl.wroom  = w_after;
        w_ctrl.fit_ok = r_fit_ok;
        w_ctrl.size   = r_size;
        w_ctrl.cap    = r_cap;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_BINS; g++) begin : g_cell
            bfbp_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (t_idx'(g)),
                .i_ctrl  (w_ctrl),
                .i_cand  (w_cand[g]),
                .o_cand  (w_cand[g+1])
            );
        end
    endgenerate

    // sequencer: idle -> scan (candidate walks the chain) -> write back and report
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_out     = r_out;
        n_out_vld = r_out_vld;

        if (o_res.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SCAN;
                    if (i_item.payload.start_new_set) begin
                        n_count = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (w_best.vld) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (w_out_free) begin
                    n_state   = ST_IDLE;
                    n_out_vld = 1'b1;
                    if (w_best.found) begin
                        // saturating count of opened bins
                        if (w_fresh && (r_count < t_cnt'(MAX_BINS))) begin
                            n_count = r_count + t_cnt'(1);
                        end
                        n_out.bin_index  = w_best.idx;
                        n_out.opened_new = w_fresh;
                        n_out.room_after = w_after;
                        n_out.no_fit     = 1'b0;
                        n_out.bins_used  = (w_fresh && (r_count < t_cnt'(MAX_BINS)))
                                           ? r_count + t_cnt'(1) : r_count;
                    end else begin
                        n_out.bin_index  = '0;
                        n_out.opened_new = 1'b0;
                        n_out.room_after = '0;
                        n_out.no_fit     = 1'b1;
                        n_out.bins_used  = r_count;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_launch  <= 1'b0;
            r_count   <= '0;
            r_cap     <= t_size'(65535);
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_launch  <= w_accept;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // item payload, capacity check done once per item
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_accept) begin
            r_size   <= i_item.payload.item_size;
            r_fit_ok <= (i_item.payload.item_size <= r_cap);
        end
    end

    // one item in flight at a time
    assign i_item.ready  = (r_state == ST_IDLE);
    assign o_res.valid   = r_out_vld;
    assign o_res.payload = r_out;

endmodule

[sv/bfbp_chk.sv]
// bfbp_chk: port-level checks for best_fit_bin_packing, bound to the top level
// depends on bfbp_pkg

module bfbp_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input bfbp_pkg::t_out_item i_out_payload
);
    import bfbp_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("result changed while stalled");

    // no fit reports zero bin, zero room, not opened
    a_no_fit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.no_fit |->
            (i_out_payload.bin_index == '0) && (i_out_payload.room_after == '0)
            && !i_out_payload.opened_new)
        else $error("no_fit result carries placement data");

    // an opened bin is counted
    a_open_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.opened_new |->
            (i_out_payload.bins_used != '0))
        else $error("opened bin not counted");

    // one request in flight: not ready right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken during a scan");

endmodule

bind best_fit_bin_packing bfbp_chk u_bfbp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_payload (o_res.payload)
);

[tb/sv/tb_top.sv]
// tb_top: self-checking testbench for best_fit_bin_packing, with a directed table and
// random phases of requests, checked against an in-bench best-fit placement predictor
// depends on bfbp_pkg, bfbp_in_if, bfbp_out_if and the best_fit_bin_packing rtl

module tb_top;
    import bfbp_pkg::*;

    localparam int RAND_REQS   = 1450;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 1500;   // long receiver hold-off, in clock cycles
    localparam int DRAIN_WAIT  = 80;     // quiet tail after the last result, in clock cycles

    typedef enum logic { ROW_REQ, ROW_CAP } t_row_kind;
    typedef enum logic [1:0] { PH_MIXED, PH_FILL, PH_ZEROS } t_phase_kind;

    // one line of the directed table: a request or a capacity write
    typedef struct {
        t_row_kind kind;
        t_size     size;
        logic      start;
        bit        typed;
        t_out_item want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_size i_cfg_data;

    bfbp_in_if  in_if ();
    bfbp_out_if res_if ();

    best_fit_bin_packing DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (in_if),
        .o_res      (res_if)
    );

    // placement predictor state, a private copy of the block's bins
    logic  bin_open [MAX_BINS];
    t_size bin_left [MAX_BINS];
    t_cnt  open_cnt;
    t_size cap_reg;

    t_out_item placed_q [$];   // expected placements, oldest first
    t_row      drill_q [$];    // directed table

    int n_err       = 0;
    int n_req       = 0;
    int n_cap_wr    = 0;
    int n_nofit     = 0;
    int n_fresh     = 0;
    int peak_used   = 0;
    int n_cycles    = 0;
    int next_gap    = 0;
    bit valid_up    = 0;   // valid left high after the last accept
    bit fast_in     = 0;   // no sender gaps in this phase

    // clock, period 2
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // best fit: smallest room that still holds the item, lowest bin on ties
    function automatic t_out_item place_item(input t_size sz, input logic st);
        t_out_item r;
        logic      found;
        t_idx      best;
        t_size     best_left;
        t_size     left;
        logic      fresh;
        r         = '0;
        found     = 1'b0;
        best      = '0;
        best_left = '0;
        // a start empties the bins even when the item then fails to fit
        if (st) begin
            foreach (bin_open[i]) bin_open[i] = 1'b0;
            open_cnt = '0;
        end
        // an item above capacity never fits, even into older roomier bins
        if (sz <= cap_reg) begin
            for (int i = 0; i < MAX_BINS; i++) begin
                // bins never touched count as a full capacity of room
                left = bin_open[i] ? bin_left[i] : cap_reg;
                if (left >= sz && (!found || left < best_left)) begin
                    found     = 1'b1;
                    best      = t_idx'(i);
                    best_left = left;
                end
            end
        end
        if (!found) begin
            r.bins_used = open_cnt;
            r.no_fit    = 1'b1;
            return r;
        end
        // a bin still at capacity counts as opened again, zero-size items included
        fresh = (best_left == cap_reg);
        if (fresh && open_cnt < MAX_BINS) open_cnt++;
        bin_open[best] = 1'b1;
        bin_left[best] = best_left - sz;
        r.bin_index    = best;
        r.opened_new   = fresh;
        r.bins_used    = open_cnt;
        r.room_after   = best_left - sz;
        return r;
    endfunction

    function automatic void add_req(input t_size sz, input logic st, input bit typed = 0,
                                    input int idx = 0, input int op = 0, input int used = 0,
                                    input int room = 0, input int nf = 0);
        t_row row;
        row.kind             = ROW_REQ;
        row.size             = sz;
        row.start            = st;
        row.typed            = typed;
        row.want.bin_index   = t_idx'(idx);
        row.want.opened_new  = op[0];
        row.want.bins_used   = t_cnt'(used);
        row.want.room_after  = t_size'(room);
        row.want.no_fit      = nf[0];
        drill_q = {drill_q, row};
    endfunction

    function automatic void add_cap(input t_size v);
        t_row row;
        row       = '{kind: ROW_CAP, size: v, start: 1'b0, typed: 1'b0, want: '0};
        drill_q = {drill_q, row};
    endfunction

    // offer one request, wait for the accept, then log what must come back
    task automatic send_req(input t_size sz, input logic st, input bit typed,
                            input t_out_item want);
        t_out_item pred;
        repeat (next_gap) @(posedge i_clk);
        in_if.valid                 <= 1'b1;
        in_if.payload.item_size     <= sz;
        in_if.payload.start_new_set <= st;
        do @(posedge i_clk); while (!in_if.ready);
        // predictor always advances; typed rows override what gets compared
        pred = place_item(sz, st);
        placed_q = {placed_q, (typed ? want : pred)};
        n_req++;
        // valid only drops when a gap follows, so back-to-back requests keep it high
        next_gap = fast_in ? 0 : $urandom_range(0, 10);
        valid_up = (next_gap == 0);
        if (!valid_up) in_if.valid <= 1'b0;
    endtask

    task automatic drop_and_drain();
        if (valid_up) begin
            in_if.valid <= 1'b0;
            valid_up = 0;
        end
        while (placed_q.size() != 0) @(posedge i_clk);
    endtask

    // capacity only changes while nothing is in flight
    task automatic write_cap(input t_size v);
        drop_and_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cap_reg = v;
        n_cap_wr++;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            n_err++;
        end
    endfunction

    // result side: compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin : res_check
        t_out_item want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (placed_q.size() == 0) begin
                $display("%0t: result with no request pending, actual %p",
                         $time, res_if.payload);
                n_err++;
            end else begin
                want = placed_q.pop_front();
                check_field("bin_index", want.bin_index, res_if.payload.bin_index);
                check_field("opened_new", want.opened_new, res_if.payload.opened_new);
                check_field("bins_used", want.bins_used, res_if.payload.bins_used);
                check_field("room_after", want.room_after, res_if.payload.room_after);
                check_field("no_fit", want.no_fit, res_if.payload.no_fit);
            end
            if (res_if.payload.no_fit) n_nofit++;
            if (res_if.payload.opened_new) n_fresh++;
            if (int'(res_if.payload.bins_used) > peak_used)
                peak_used = res_if.payload.bins_used;
        end
    end

    // receiver: random stalls per result, stall-free stretches, and two long hold-offs
    // during which the sender keeps offering so the block backs up into its input
    initial begin : res_drain
        int hold;
        int nres;
        bit eager;
        res_if.ready = 1'b0;
        nres  = 0;
        eager = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (nres % 64 == 0) eager = ($urandom_range(0, 3) == 0);
            if (nres == 250 || nres == 1000) hold = LONG_HOLD;
            else hold = eager ? 0 : $urandom_range(0, 10);
            if (hold != 0) begin
                res_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            nres++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d placements still pending", $time, placed_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        t_phase_kind ph;
        t_size       cap;
        t_size       sz;
        logic        st;
        int          len;
        int          pick;
        int          n_rand;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;

        // predictor reset: empty bins, count zero, full 16-bit capacity
        foreach (bin_open[i]) begin
            bin_open[i] = 1'b0;
            bin_left[i] = '0;
        end
        open_cnt = '0;
        cap_reg  = 16'hFFFF;
        n_rand   = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at reset capacity: zero-size items reopen a full bin,
        // then a full-size item, then a start over used bins
        add_req(16'd0, 1'b0, 1, 0, 1, 1, 65535, 0);
        add_req(16'd0, 1'b0, 1, 0, 1, 2, 65535, 0);
        add_req(16'hFFFF, 1'b0, 1, 0, 1, 3, 0, 0);
        add_req(16'hFFFF, 1'b0);
        add_req(16'd0, 1'b0);
        add_req(16'hFFFF, 1'b1, 1, 0, 1, 1, 0, 0);
        add_req(16'd40000, 1'b0);
        add_req(16'd30000, 1'b0);
        add_req(16'd20000, 1'b0);
        // shrink mid-set: used bins keep their larger room, but oversize items still fail
        add_cap(16'd100);
        add_req(16'd101, 1'b0);
        add_req(16'd50, 1'b0);
        add_req(16'd5535, 1'b0);
        // start together with no fit still empties the bins
        add_req(16'd101, 1'b1, 1, 0, 0, 0, 0, 1);
        add_req(16'd100, 1'b0, 1, 0, 1, 1, 0, 0);
        add_req(16'd100, 1'b0);
        // equal rooms: tie goes to the lower bin
        add_cap(16'd1000);
        add_req(16'd600, 1'b1);
        add_req(16'd600, 1'b0);
        add_req(16'd300, 1'b0);
        add_req(16'd400, 1'b0);
        add_req(16'd1000, 1'b0);
        // zero capacity: only zero-size items fit, and each reopens a bin
        add_cap(16'd0);
        add_req(16'd0, 1'b1, 1, 0, 1, 1, 0, 0);
        add_req(16'd0, 1'b0, 1, 0, 1, 2, 0, 0);
        add_req(16'd1, 1'b0, 1, 0, 0, 2, 0, 1);
        // grow back: unused bins take the new capacity
        add_cap(16'hFFFF);
        add_req(16'hFFFF, 1'b0);
        add_req(16'h5A5A, 1'b1);

        next_gap = $urandom_range(0, 10);
        foreach (drill_q[r]) begin
            if (drill_q[r].kind == ROW_CAP) write_cap(drill_q[r].size);
            else send_req(drill_q[r].size, drill_q[r].start, drill_q[r].typed,
                          drill_q[r].want);
        end

        // random phases, each preceded by a capacity write (the sender drains first);
        // fill phases run past 64 bins into no-fit, zero phases push the count to saturation
        while (n_rand < RAND_REQS) begin
            case ($urandom_range(0, 5))
                0:       cap = 16'd1;
                1:       cap = 16'hFFFF;
                2:       cap = t_size'($urandom_range(2, 16));
                3:       cap = t_size'($urandom_range(17, 1000));
                4:       cap = t_size'($urandom_range(1, 65535));
                default: cap = 16'hFFFF - t_size'($urandom_range(0, 15));
            endcase
            write_cap(cap);
            case ($urandom_range(0, 3))
                2:       ph = PH_FILL;
                3:       ph = PH_ZEROS;
                default: ph = PH_MIXED;
            endcase
            fast_in = ($urandom_range(0, 3) == 0);
            len     = (ph == PH_MIXED) ? $urandom_range(15, 50) : $urandom_range(66, 90);
            for (int k = 0; k < len && n_rand < RAND_REQS; k++) begin
                if (k == 0) st = (ph == PH_MIXED) ? 1'($urandom_range(0, 1)) : 1'b1;
                else st = ($urandom_range(0, 49) == 0);
                pick = $urandom_range(0, 99);
                case (ph)
                    PH_FILL: begin
                        if (pick < 70) sz = cap;
                        else if (pick < 90) sz = t_size'($urandom_range(cap, cap / 2));
                        else sz = t_size'($urandom);
                    end
                    PH_ZEROS: begin
                        if (pick < 80) sz = '0;
                        else sz = t_size'($urandom_range(0, cap));
                    end
                    default: begin
                        if (pick < 5) sz = '0;
                        else if (pick < 10) sz = cap;
                        else if (pick < 18) sz = t_size'($urandom);
                        else if (pick < 22) sz = 16'hFFFF;
                        else if (pick < 60) sz = t_size'($urandom_range(cap, cap / 2));
                        else sz = t_size'($urandom_range(0, cap));
                    end
                endcase
                send_req(sz, st, 1'b0, '0);
                n_rand++;
            end
        end

        // let the last placements come back, then a short quiet tail
        drop_and_drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("run covered %0d requests over %0d capacity writes", n_req, n_cap_wr);
        $display("%0d fresh-bin placements, %0d no-fit results, peak bins_used %0d",
                 n_fresh, n_nofit, peak_used);
        if (n_err == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
